>>> design/literal_substring_match_stream_unit_defines.svh
// Assertion macros shared by the substring match unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef LITERAL_SUBSTRING_MATCH_STREAM_UNIT_DEFINES_SVH
`define LITERAL_SUBSTRING_MATCH_STREAM_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lsm_pkg.sv
// Types, constants and helpers of the substring match unit.
// Depends on nothing; used by all modules.
package lsm_pkg;

    localparam int DEF_MAX_PATTERN     = 16;
    localparam int DEF_MAX_LINE_LENGTH = 4096;
    localparam int DEF_MAX_LINES       = 65536;

    typedef enum logic [1:0] {
        FUNC_TEXT = 2'd0,
        FUNC_EOL  = 2'd1,
        FUNC_DOC  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_PAT_LO    = 2'd0,
        CFG_PAT_HI    = 2'd1,
        CFG_PAT_LEN   = 2'd2,
        CFG_CASE_SENS = 2'd3
    } t_cfg_idx;

    // window control, same for every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    // fold ASCII upper case to lower case unless comparing exactly
    function automatic logic [7:0] fold(input logic [7:0] b, input logic case_sens);
        logic [7:0] r;
        r = b;
        if (!case_sens && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> design/lsm_if.sv
// Stream and configuration channels of the substring match unit.
// Depends on nothing; valid/ready handshake, a word moves when both are high.
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] text_byte;
    modport source (output valid, output func, output text_byte, input ready);
    modport sink   (input valid, input func, input text_byte, output ready);
endinterface

interface lsm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_line;
    logic [11:0] match_start_column;
    logic [12:0] match_end_column;
    logic        position_saturated;
    modport source (output valid, output match_line, output match_start_column,
                    output match_end_column, output position_saturated, input ready);
    modport sink   (input valid, input match_line, input match_start_column,
                    input match_end_column, input position_saturated, output ready);
endinterface

interface lsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/literal_substring_match_stream_unit.sv
// Streaming literal substring matcher. Takes one word per cycle (a text byte,
// an end of line or a new-document marker) and sustains one word every cycle
// while the result side is ready. A match is reported in the cycle after its last
// byte is taken, from a single output register; while a result waits there and
// the result side holds off, the input stalls. The window is a row of
// MAX_PATTERN byte cells that all compare in parallel against the configured
// pattern in the cycle a byte arrives; that single compare-and-reduce sets the
// cycle. Matches never overlap, case folding covers ASCII A-Z only, and line
// and column counters stop at their limits. Configuration takes effect on the
// next word.
// Depends on lsm_pkg, lsm_if, lsm_window and the defines header.
`include "literal_substring_match_stream_unit_defines.svh"

module literal_substring_match_stream_unit
    import lsm_pkg::*;
#(
    parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
    parameter int MAX_LINE_LENGTH = DEF_MAX_LINE_LENGTH,
    parameter int MAX_LINES       = DEF_MAX_LINES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lsm_in_if.sink    i_in,
    lsm_out_if.source o_out,
    lsm_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(MAX_LINE_LENGTH + 1);
    localparam int AW = CW + 1;
    localparam int LW = $clog2(MAX_LINES);
    localparam logic [CW-1:0] COL_MAX  = CW'(MAX_LINE_LENGTH);
    localparam logic [AW-1:0] COL_MAXA = AW'(MAX_LINE_LENGTH);
    localparam logic [LW-1:0] LINE_MAX = LW'(MAX_LINES - 1);
    localparam logic [6:0]    PAT_MAX  = 7'(MAX_PATTERN);

    // configuration
    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [4:0]  r_pat_len;
    logic        r_case_sens;

    // position state
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_nas;
    logic [LW-1:0] r_line;

    // output register
    logic        r_ovalid;
    logic [15:0] r_oline;
    logic [11:0] r_ostart;
    logic [12:0] r_oend;
    logic        r_osat;

    logic          in_ready;
    logic          acc;
    t_func         func;
    t_win_ctl      win_ctl;
    logic          win_hit;
    logic          col_full;
    logic          len_ok;
    logic [AW-1:0] end_col;
    logic [AW-1:0] start_col;
    logic          hit;
    logic          sat;
    logic [31:0]   line32;
    logic [31:0]   start32;
    logic [31:0]   end32;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_pat_len   <= '0;
            r_case_sens <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PAT_LO:    r_pat_lo    <= i_cfg.data;
                CFG_PAT_HI:    r_pat_hi    <= i_cfg.data;
                CFG_PAT_LEN:   r_pat_len   <= i_cfg.data[4:0];
                CFG_CASE_SENS: r_case_sens <= i_cfg.data[0];
            endcase
        end
    end

    // input moves whenever the output register is free or draining
    assign in_ready   = !r_ovalid || o_out.ready;
    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;
    assign func       = t_func'(i_in.func);

    always_comb begin
        win_ctl = '0;
        if (acc) begin
            case (func) inside
                FUNC_TEXT:          win_ctl.shift = 1'b1;
                FUNC_EOL, FUNC_DOC: win_ctl.clear = 1'b1;
                default:            win_ctl = '0;
            endcase
        end
    end

    lsm_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (win_ctl),
        .i_byte      (i_in.text_byte),
        .i_pat_lo    (r_pat_lo),
        .i_pat_hi    (r_pat_hi),
        .i_pat_len   (r_pat_len),
        .i_case_sens (r_case_sens),
        .o_hit       (win_hit)
    );

    assign col_full  = r_col == COL_MAX;
    assign len_ok    = (r_pat_len != 5'd0) && ({2'b00, r_pat_len} <= PAT_MAX);
    assign end_col   = AW'(r_col) + AW'(1);
    assign start_col = end_col - AW'(r_pat_len);
    // start test is valid only once enough bytes are on the line
    assign hit = win_ctl.shift && !col_full && len_ok && (end_col >= AW'(r_pat_len))
                 && (start_col >= AW'(r_nas)) && win_hit;
    assign sat = (r_line == LINE_MAX) || (end_col >= COL_MAXA);

    assign line32  = 32'(r_line);
    assign start32 = 32'(start_col);
    assign end32   = 32'(end_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_nas  <= '0;
            r_line <= '0;
        end else if (acc) begin
            case (func)
                FUNC_TEXT: begin
                    if (!col_full) begin
                        r_col <= end_col[CW-1:0];
                    end
                    if (hit) begin
                        r_nas <= end_col[CW-1:0];
                    end
                end
                FUNC_EOL: begin
                    r_col <= '0;
                    r_nas <= '0;
                    if (r_line != LINE_MAX) begin
                        r_line <= r_line + LW'(1);
                    end
                end
                FUNC_DOC: begin
                    r_col  <= '0;
                    r_nas  <= '0;
                    r_line <= '0;
                end
                default: begin
                    r_col <= r_col;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (acc && hit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && hit) begin
            r_oline  <= line32[15:0];
            r_ostart <= start32[11:0];
            r_oend   <= end32[12:0];
            r_osat   <= sat;
        end
    end

    assign o_out.valid              = r_ovalid;
    assign o_out.match_line         = r_oline;
    assign o_out.match_start_column = r_ostart;
    assign o_out.match_end_column   = r_oend;
    assign o_out.position_saturated = r_osat;

    `LSM_ASSERT_NOW(a_line_bound, i_clk, i_rst_n, 1'b1, r_line <= LINE_MAX, "line counter past limit")
    `LSM_ASSERT_NOW(a_nas_bound, i_clk, i_rst_n, 1'b1, r_nas <= r_col, "next start beyond column")
    `LSM_ASSERT_NEXT(a_eol_clear, i_clk, i_rst_n, acc && (func == FUNC_EOL), (r_col == '0) && (r_nas == '0), "line end did not clear column")
    `LSM_ASSERT_NOW(a_result_src, i_clk, i_rst_n, $rose(r_ovalid), $past(acc && (func == FUNC_TEXT)), "result without text byte")

endmodule

>>> design/lsm_cell.sv
// One window cell: holds one text byte and compares the byte it takes in
// against its pattern byte. Depends on lsm_pkg.
module lsm_cell
    import lsm_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_win_ctl    i_ctl,
    input  logic [7:0]  i_byte,
    input  logic [63:0] i_pat_lo,
    input  logic [63:0] i_pat_hi,
    input  logic [4:0]  i_pat_len,
    input  logic        i_case_sens,
    output logic [7:0]  o_byte,
    output logic        o_hit
);

    localparam logic [6:0] IDX7 = 7'(IDX);

    logic [7:0]   r_byte;
    logic         active;
    logic [4:0]   pidx;
    logic [127:0] pat_all;
    logic [7:0]   pat_byte;

    // cell IDX (0 newest) lines up with pattern byte len-1-IDX
    assign active  = {2'b00, i_pat_len} > IDX7;
    assign pidx    = i_pat_len - IDX7[4:0] - 5'd1;
    assign pat_all = {i_pat_hi, i_pat_lo};
    assign pat_byte = pidx[4] ? 8'h00 : pat_all[{pidx[3:0], 3'b000} +: 8];

    assign o_hit  = !active || (fold(i_byte, i_case_sens) == fold(pat_byte, i_case_sens));
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else if (i_ctl.clear) begin
            r_byte <= 8'h00;
        end else if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> design/lsm_window.sv
// Row of window cells, newest byte entering cell 0 and moving one cell per
// text byte. Depends on lsm_pkg and lsm_cell.
module lsm_window
    import lsm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_win_ctl    i_ctl,
    input  logic [7:0]  i_byte,
    input  logic [63:0] i_pat_lo,
    input  logic [63:0] i_pat_hi,
    input  logic [4:0]  i_pat_len,
    input  logic        i_case_sens,
    output logic        o_hit
);

    logic [7:0]             cell_in  [MAX_PATTERN];
    logic [7:0]             cell_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;

    assign cell_in[0] = i_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        lsm_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_byte      (cell_in[k]),
            .i_pat_lo    (i_pat_lo),
            .i_pat_hi    (i_pat_hi),
            .i_pat_len   (i_pat_len),
            .i_case_sens (i_case_sens),
            .o_byte      (cell_out[k]),
            .o_hit       (hits[k])
        );
    end

    assign o_hit = &hits;

endmodule

>>> dv/lsm_match_checker.sv
// Scoreboard for the substring match unit: watches the input, result and config channels,
// predicts each match from its own copy of the window and counters, and compares fields.
// Depends on lsm_pkg and the channel interfaces in lsm_if.
module lsm_match_checker
    import lsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsm_in_if    i_in,
    lsm_out_if   i_out,
    lsm_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = DEF_MAX_PATTERN;
    localparam int LINE_LIMIT = DEF_MAX_LINE_LENGTH;
    localparam int LAST_LINE  = DEF_MAX_LINES - 1;

    typedef struct packed {
        logic [15:0] line;
        logic [11:0] start_col;
        logic [12:0] end_col;
        logic        sat;
    } t_match;

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        exact;
    logic [7:0]  recent [WINDOW];
    int          col_cnt;
    int          line_cnt;
    int          next_start;
    t_match      expected_matches [$];
    int          fail_count = 0;
    int          pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (!exact && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_char(input int i);
        if (i < 8) begin
            return pat_lo[8*i +: 8];
        end
        if (i < 16) begin
            return pat_hi[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic void clear_line();
        foreach (recent[i]) recent[i] = 8'h00;
        col_cnt    = 0;
        next_start = 0;
    endfunction

    // shift a byte into the window and queue the match it completes, if any
    function automatic void scan_text_byte(input logic [7:0] b);
        int     len;
        int     end_col;
        int     start_col;
        bit     hit;
        t_match m;
        for (int i = WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = b;
        if (col_cnt >= LINE_LIMIT) begin
            return;
        end
        len = pat_len;
        if (len != 0 && len <= WINDOW && col_cnt + 1 >= len) begin
            end_col   = col_cnt + 1;
            start_col = end_col - len;
            hit       = (start_col >= next_start);
            for (int i = 0; i < len; i++) begin
                if (to_lower(pattern_char(i)) != to_lower(recent[len-1-i])) hit = 1'b0;
            end
            if (hit) begin
                m.line      = line_cnt[15:0];
                m.start_col = start_col[11:0];
                m.end_col   = end_col[12:0];
                m.sat       = (line_cnt >= LAST_LINE) || (end_col >= LINE_LIMIT);
                expected_matches = {expected_matches, m};
                next_start = end_col;
            end
        end
        col_cnt++;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            pat_lo   = '0;
            pat_hi   = '0;
            pat_len  = '0;
            exact    = 1'b1;
            line_cnt = 0;
            clear_line();
            expected_matches.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PAT_LO:    pat_lo  = i_cfg.data;
                    CFG_PAT_HI:    pat_hi  = i_cfg.data;
                    CFG_PAT_LEN:   pat_len = i_cfg.data[4:0];
                    CFG_CASE_SENS: exact   = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.func)
                    FUNC_TEXT: scan_text_byte(i_in.text_byte);
                    FUNC_EOL: begin
                        if (line_cnt < LAST_LINE) line_cnt++;
                        clear_line();
                    end
                    FUNC_DOC: begin
                        clear_line();
                        line_cnt = 0;
                    end
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected match word: line %0d, columns %0d..%0d",
                           i_out.match_line, i_out.match_start_column, i_out.match_end_column);
                    fail_count++;
                end else begin
                    want = expected_matches.pop_front();
                    check_field("match_line", want.line, i_out.match_line);
                    check_field("match_start_column", want.start_col, i_out.match_start_column);
                    check_field("match_end_column", want.end_col, i_out.match_end_column);
                    check_field("position_saturated", want.sat, i_out.position_saturated);
                end
            end
        end
        pending = expected_matches.size();
    end

endmodule

>>> dv/testbench.sv
// Top of the substring match unit bench: clock, reset, stimulus and verdict.
// Drives text, markers and register writes; lsm_match_checker does the predicting.
// Depends on lsm_pkg, lsm_if, the unit itself and lsm_match_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsm_pkg::*;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         RANDOM_ITEMS  = 1400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   steady  = 1'b0;
    int   holds_requested = 0;
    int   holds_done      = 0;
    int   fail_count;
    int   pending;

    lsm_in_if  in_ch ();
    lsm_out_if out_ch ();
    lsm_cfg_if cfg_ch ();

    literal_substring_match_stream_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lsm_match_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_requested) begin
                holds_done++;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_ch.ready = steady || ($urandom_range(0, 99) >= 29);
        end
    end

    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic push_word(input logic [1:0] f, input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 29) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.func      = f;
        in_ch.text_byte = b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_word(FUNC_TEXT, s[i]);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        wait (pending == 0);
        // a marker or a non-matching byte may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input int len, input bit exact);
        drain();
        write_reg(CFG_PAT_LO, lo);
        write_reg(CFG_PAT_HI, hi);
        write_reg(CFG_PAT_LEN, 64'(len));
        write_reg(CFG_CASE_SENS, {63'b0, exact});
    endtask

    // small alphabet so matches are frequent, with the folding borders and any byte
    function automatic logic [7:0] pick_char();
        logic [7:0] common_chars [4] = '{8'h61, 8'h62, 8'h41, 8'h42};
        logic [7:0] border_chars [6] = '{8'h40, 8'h5A, 8'h5B, 8'h60, 8'h7A, 8'h7B};
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return common_chars[$urandom_range(0, 3)];
        if (r == 7) return border_chars[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_setting(input int len, input bit exact, input int n_items,
                                  inout int total);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  pat [16];
        logic [7:0]  c;
        int          sent;
        int          r;
        sent = 0;
        if ($urandom_range(0, 3) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end else begin
            for (int i = 0; i < 8; i++) begin
                lo[8*i +: 8] = pick_char();
                hi[8*i +: 8] = pick_char();
            end
        end
        for (int i = 0; i < 16; i++) pat[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        set_pattern(lo, hi, len, exact);
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                push_word(FUNC_DOC, 8'($urandom_range(0, 255)));
            end else if (r < 5) begin
                push_word(FUNC_EOL, 8'($urandom_range(0, 255)));
            end else if (r < 6) begin
                push_word(FUNC_RESERVED, 8'($urandom_range(0, 255)));
                continue;
            end else if (r < 7) begin
                drain();
                continue;
            end else if (r < 40 && len >= 1 && len <= 16) begin
                // embed the pattern, case flipped now and then, sometimes broken
                for (int i = 0; i < len; i++) begin
                    c = pat[i];
                    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A
                        && $urandom_range(0, 3) < (exact ? 1 : 2)) c = c ^ 8'h20;
                    if ($urandom_range(0, 29) == 0) c = pick_char();
                    push_word(FUNC_TEXT, c);
                end
                sent += len - 1;
            end else begin
                push_word(FUNC_TEXT, pick_char());
            end
            sent++;
        end
        total += sent;
    endtask

    initial begin
        int total;
        int s;
        int len;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_TEXT;
        in_ch.text_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_PAT_LO;
        cfg_ch.data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty pattern after reset never matches
        push_word(FUNC_TEXT, 8'h00);
        push_word(FUNC_TEXT, 8'hFF);
        push_word(FUNC_EOL, 8'hFF);

        set_pattern(64'h636261, 64'h0, 3, 1'b1);
        send_text("abcabcABC");
        send_text("ab");
        push_word(FUNC_RESERVED, 8'h63);    // ignored, window keeps "ab"
        send_text("c");
        send_text("ab");
        push_word(FUNC_EOL, 8'h00);
        send_text("c");
        send_text("ab");
        push_word(FUNC_DOC, 8'h00);
        send_text("c");

        // folding borders: only A-Z fold
        set_pattern(64'h5B5A40, 64'h0, 3, 1'b0);
        send_text("@z[`z{");
        set_pattern(64'h4161, 64'h0, 2, 1'b0);
        send_text("aaaA");                  // non-overlapping: 0..2 and 2..4

        set_pattern('1, '1, 16, 1'b1);
        push_word(FUNC_EOL, 8'h00);
        repeat (16) push_word(FUNC_TEXT, 8'hFF);

        // every byte matches while the result side holds off: input must stall
        steady = 1'b0;
        set_pattern(64'h7A, 64'h0, 1, 1'b1);
        holds_requested++;
        repeat (80) push_word(FUNC_TEXT, 8'h7A);
        drain();

        total = 0;
        s = 0;
        while (total < RANDOM_ITEMS) begin
            case (s % 8)
                0:       len = 1;
                1:       len = 16;
                2:       len = 0;
                3:       len = $urandom_range(17, 31);
                default: len = $urandom_range(2, 8);
            endcase
            steady = (s == 0);
            random_setting(len, (s % 2 == 0), (len == 0 || len > 16) ? 60 : 220, total);
            s++;
        end
        steady = 1'b0;

        drain();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
